// ----- design/gbn_pkg.sv -----
`default_nettype none

package gbn_pkg;

    localparam int unsigned WORD_W = 16;
    localparam int unsigned FLAG_W = 5;
    localparam int unsigned PLEN_W = 13;

    // header word positions; index saturates past the last header word
    localparam int unsigned IDX_W = 3;
    localparam logic [IDX_W-1:0] IDX_SEQ  = 3'd0;
    localparam logic [IDX_W-1:0] IDX_FLAG = 3'd2;
    localparam logic [IDX_W-1:0] IDX_LEN  = 3'd4;
    localparam logic [IDX_W-1:0] IDX_SAT  = 3'd5;

    localparam logic [WORD_W-1:0] MAX_PAYLOAD_BYTES = 16'd6666;
    localparam logic [WORD_W-1:0] SUM_GOOD          = 16'hffff;
    localparam logic [WORD_W-1:0] ACK_RESET         = 16'hffff;

    localparam logic [WORD_W-1:0] FLAG_ACK = 16'h0002;
    localparam logic [WORD_W-1:0] FLAG_FIN = 16'h0004;
    localparam logic [WORD_W-1:0] FLAG_LAS = 16'h0008;

    typedef enum logic [2:0] {
        OUTCOME_ACCEPTED  = 3'd0,
        OUTCOME_OUT_ORDER = 3'd1,
        OUTCOME_SUM_ERROR = 3'd2,
        OUTCOME_FIN_ACKED = 3'd3,
        OUTCOME_IGNORED   = 3'd4
    } outcome_t;

    // 16-bit ones-complement add with end-around carry
    function automatic logic [WORD_W-1:0] oc_add(
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b
    );
        logic [WORD_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            oc_add = s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/gobackn_receiver_with_checksum_unit.sv -----
// Go-back-N receiver with Internet checksum.
// A word request reaches the reply through the input register, then the reply register.
// Throughput: one word per cycle while not stalled; a packet of N words yields one reply after its last word.
// The input stalls only when a last word waits and the held reply is itself stalled.
// Reset (rst_n low, async): expected seq 0, last ACK 0xFFFF, open, not finished, no reply.
`default_nettype none

module gobackn_receiver_with_checksum_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // word request channel
    input  wire logic        valid,
    output logic             stall,
    input  wire logic [15:0] word,
    input  wire logic        last,
    input  wire logic        single_byte,

    // reply request channel
    output logic             reply_valid,
    input  wire logic        reply_stall,
    output logic [15:0]      reply_ack,
    output logic [4:0]       reply_flag,
    output logic [15:0]      reply_checksum,
    output logic [2:0]       outcome,
    output logic             file_finished,
    output logic [12:0]      payload_length
);

    // ---------------- input register ----------------
    logic                            in_valid_reg;
    logic [gbn_pkg::WORD_W-1:0]      in_word_reg;
    logic                            in_last_reg;
    logic                            in_single_reg;

    // ---------------- receiver state ----------------
    logic [gbn_pkg::WORD_W-1:0]      expected_seq_reg, expected_seq_next;
    logic [gbn_pkg::WORD_W-1:0]      last_ack_reg, last_ack_next;
    logic [gbn_pkg::WORD_W-1:0]      sum_reg, sum_next;
    logic [gbn_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic [gbn_pkg::WORD_W-1:0]      hdr_seq_reg, hdr_seq_next;
    logic [gbn_pkg::WORD_W-1:0]      hdr_flag_reg, hdr_flag_next;
    logic [gbn_pkg::WORD_W-1:0]      hdr_len_reg, hdr_len_next;
    logic                            closed_reg, closed_next;
    logic                            finished_reg, finished_next;

    // ---------------- reply register ----------------
    logic                            out_valid_reg;
    logic [gbn_pkg::WORD_W-1:0]      out_ack_reg;
    logic [gbn_pkg::WORD_W-1:0]      out_csum_reg;
    gbn_pkg::outcome_t               out_outcome_reg;
    logic                            out_finished_reg;
    logic [gbn_pkg::PLEN_W-1:0]      out_plen_reg;

    // ---------------- datapath ----------------
    logic                            out_free;
    logic                            advance;
    logic [gbn_pkg::WORD_W-1:0]      w;
    logic [gbn_pkg::WORD_W-1:0]      word_sum;
    logic [gbn_pkg::WORD_W-1:0]      ack_sel;
    gbn_pkg::outcome_t               outcome_sel;
    logic [gbn_pkg::PLEN_W-1:0]      plen_sel;

    // the reply slot frees up when empty or being taken this cycle
    assign out_free = !out_valid_reg || !reply_stall;
    // non-last words never need the reply slot
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign stall    = in_valid_reg && in_last_reg && !out_free;

    always_comb
    begin
        // pad byte of a one-byte final word reads as zero
        w = in_word_reg;
        if (in_last_reg && in_single_reg)
        begin
            w[15:8] = 8'h00;
        end

        hdr_seq_next  = hdr_seq_reg;
        hdr_flag_next = hdr_flag_reg;
        hdr_len_next  = hdr_len_reg;
        case (idx_reg)
            gbn_pkg::IDX_SEQ:
            begin
                // first word of a packet clears the captured header
                hdr_seq_next  = w;
                hdr_flag_next = '0;
                hdr_len_next  = '0;
            end
            gbn_pkg::IDX_FLAG: hdr_flag_next = w;
            gbn_pkg::IDX_LEN:  hdr_len_next  = w;
            default:           ;
        endcase

        word_sum = gbn_pkg::oc_add(sum_reg, w);

        expected_seq_next = expected_seq_reg;
        last_ack_next     = last_ack_reg;
        closed_next       = closed_reg;
        finished_next     = finished_reg;
        plen_sel          = '0;

        if (closed_reg)
        begin
            outcome_sel = gbn_pkg::OUTCOME_IGNORED;
        end
        else if (word_sum != gbn_pkg::SUM_GOOD)
        begin
            outcome_sel = gbn_pkg::OUTCOME_SUM_ERROR;
        end
        else if (hdr_flag_next == gbn_pkg::FLAG_FIN)
        begin
            last_ack_next = hdr_seq_next + 16'd1;
            closed_next   = 1'b1;
            outcome_sel   = gbn_pkg::OUTCOME_FIN_ACKED;
        end
        else if (hdr_seq_next == expected_seq_reg)
        begin
            last_ack_next     = expected_seq_reg;
            expected_seq_next = expected_seq_reg + 16'd1;
            if ((hdr_flag_next & gbn_pkg::FLAG_LAS) != '0)
            begin
                finished_next = 1'b1;
            end
            // clamp to the largest payload, then keep the port width
            if (hdr_len_next > gbn_pkg::MAX_PAYLOAD_BYTES)
            begin
                plen_sel = gbn_pkg::MAX_PAYLOAD_BYTES[gbn_pkg::PLEN_W-1:0];
            end
            else
            begin
                plen_sel = hdr_len_next[gbn_pkg::PLEN_W-1:0];
            end
            outcome_sel = gbn_pkg::OUTCOME_ACCEPTED;
        end
        else
        begin
            outcome_sel = gbn_pkg::OUTCOME_OUT_ORDER;
        end

        ack_sel = last_ack_next;

        // packet end resets the per-packet counters
        if (in_last_reg)
        begin
            sum_next = '0;
            idx_next = '0;
        end
        else
        begin
            sum_next = word_sum;
            idx_next = (idx_reg == gbn_pkg::IDX_SAT) ? idx_reg : idx_reg + 3'd1;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            in_valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid && !stall)
        begin
            in_word_reg   <= word;
            in_last_reg   <= last;
            in_single_reg <= single_byte;
        end
    end

    // receiver state; decisions only commit on a last word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_seq_reg <= '0;
            last_ack_reg     <= gbn_pkg::ACK_RESET;
            sum_reg          <= '0;
            idx_reg          <= '0;
            hdr_seq_reg      <= '0;
            hdr_flag_reg     <= '0;
            hdr_len_reg      <= '0;
            closed_reg       <= 1'b0;
            finished_reg     <= 1'b0;
        end
        else if (advance)
        begin
            sum_reg      <= sum_next;
            idx_reg      <= idx_next;
            hdr_seq_reg  <= hdr_seq_next;
            hdr_flag_reg <= hdr_flag_next;
            hdr_len_reg  <= hdr_len_next;
            if (in_last_reg)
            begin
                expected_seq_reg <= expected_seq_next;
                last_ack_reg     <= last_ack_next;
                closed_reg       <= closed_next;
                finished_reg     <= finished_next;
            end
        end
    end

    // reply register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!reply_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_ack_reg      <= ack_sel;
            // reply header: seq 0, ack, flag ACK, checksum 0, length 0
            out_csum_reg     <= ~gbn_pkg::oc_add(ack_sel, gbn_pkg::FLAG_ACK);
            out_outcome_reg  <= outcome_sel;
            out_finished_reg <= finished_next;
            out_plen_reg     <= plen_sel;
        end
    end

    assign reply_valid    = out_valid_reg;
    assign reply_ack      = out_ack_reg;
    assign reply_flag     = gbn_pkg::FLAG_ACK[gbn_pkg::FLAG_W-1:0];
    assign reply_checksum = out_csum_reg;
    assign outcome        = out_outcome_reg;
    assign file_finished  = out_finished_reg;
    assign payload_length = out_plen_reg;

    // ---------------- assertions ----------------
    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |=> closed_reg)
        else $error("receiver reopened after FIN");

    a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> finished_reg)
        else $error("file_finished dropped");

    a_seq_moves_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(expected_seq_reg) |->
            (out_valid_reg && out_outcome_reg == gbn_pkg::OUTCOME_ACCEPTED))
        else $error("expected seq moved without an accepted packet");

    a_ignored_when_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg && closed_reg) |=>
            (out_valid_reg && out_outcome_reg == gbn_pkg::OUTCOME_IGNORED))
        else $error("closed receiver did not ignore packet");

endmodule

`default_nettype wire
